/* sv/dcfd_pkg.sv */
// Shared types and status codes for the DCF77 minute frame decoder.
// No dependencies; compiled first.
package dcfd_pkg;

  localparam int unsigned WordW  = 60;
  localparam int unsigned FrameW = 44;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_LEAP_END = 3'd2;
  localparam logic [2:0] ST_FRAME    = 3'd3;
  localparam logic [2:0] ST_BCD      = 3'd4;
  localparam logic [2:0] ST_RANGE    = 3'd5;
  localparam logic [2:0] ST_LEAP_BAD = 3'd6;

  // Raw digits and flags pulled out of one 44-bit frame
  typedef struct packed {
    logic       frame_ok;  // CET/CEST pair, start bit and parities good
    logic [3:0] mu;
    logic [2:0] mt;
    logic [3:0] hu;
    logic [1:0] ht;
    logic [3:0] du;
    logic [1:0] dt;
    logic [2:0] dow;
    logic [3:0] mou;
    logic       mot;
    logic [3:0] yu;
    logic [3:0] yt;
    logic       ann;
    logic       cest;
    logic       zone;
    logic       call;
  } dgt_t;

endpackage

/* sv/dcfd_if.sv */
// Valid/ready channel interfaces for the DCF77 minute frame decoder.
// Depends on dcfd_pkg (word width).
interface dcfd_in_if;
  logic                             valid;
  logic                             ready;
  logic [dcfd_pkg::WordW-1:0]       minute_word;

  modport source (output valid, output minute_word, input ready);
  modport sink   (input valid, input minute_word, output ready);
endinterface

interface dcfd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [4:0] month_day;
  logic [2:0] weekday;
  logic [3:0] month_number;
  logic [6:0] year_in_century;
  logic       summer_time;
  logic       zone_change_announced;
  logic       leap_announced;
  logic       leap_second_present;
  logic       abnormal_transmitter;

  modport source (output valid, output status, output minute, output hour,
                  output month_day, output weekday, output month_number,
                  output year_in_century, output summer_time,
                  output zone_change_announced, output leap_announced,
                  output leap_second_present, output abnormal_transmitter,
                  input ready);
  modport sink   (input valid, input status, input minute, input hour,
                  input month_day, input weekday, input month_number,
                  input year_in_century, input summer_time,
                  input zone_change_announced, input leap_announced,
                  input leap_second_present, input abnormal_transmitter,
                  output ready);
endinterface

/* sv/dcfd_field_dec.sv */
// Frame field extractor: parity/framing check and raw BCD digit pickup.
// Depends on dcfd_pkg (dgt_t).
module dcfd_field_dec (
  input  logic [dcfd_pkg::FrameW-1:0] frame_i,
  output dcfd_pkg::dgt_t              dgt_o
);
  import dcfd_pkg::*;

  logic par_bad;

  // even parity over minute, hour and date groups
  assign par_bad = (^frame_i[37:30]) | (^frame_i[29:23]) | (^frame_i[22:0]);

  assign dgt_o.frame_ok = (frame_i[41] != frame_i[40]) & frame_i[38] & ~par_bad;

  // higher bit index carries the lower weight
  assign dgt_o.mu   = {frame_i[34], frame_i[35], frame_i[36], frame_i[37]};
  assign dgt_o.mt   = {frame_i[31], frame_i[32], frame_i[33]};
  assign dgt_o.hu   = {frame_i[26], frame_i[27], frame_i[28], frame_i[29]};
  assign dgt_o.ht   = {frame_i[24], frame_i[25]};
  assign dgt_o.du   = {frame_i[19], frame_i[20], frame_i[21], frame_i[22]};
  assign dgt_o.dt   = {frame_i[17], frame_i[18]};
  assign dgt_o.dow  = {frame_i[14], frame_i[15], frame_i[16]};
  assign dgt_o.mou  = {frame_i[10], frame_i[11], frame_i[12], frame_i[13]};
  assign dgt_o.mot  = frame_i[9];
  assign dgt_o.yu   = {frame_i[5], frame_i[6], frame_i[7], frame_i[8]};
  assign dgt_o.yt   = {frame_i[1], frame_i[2], frame_i[3], frame_i[4]};
  assign dgt_o.ann  = frame_i[39];
  assign dgt_o.cest = frame_i[41];
  assign dgt_o.zone = frame_i[42];
  assign dgt_o.call = frame_i[43];

endmodule

/* sv/dcf77_minute_frame_decoder.sv */
// DCF77 minute frame decoder, top level: three-stage valid/ready pipeline.
// Depends on dcfd_pkg, dcfd_if (dcfd_in_if, dcfd_out_if) and dcfd_field_dec.
// Result path: registered in stage 1, stage 2 and the output stage, in that order.
// Throughput: one item per cycle; a stage advances when the one after it is empty or moving,
//   so a held result stalls the input only once all three stages are full.
// Reset: rst_ni async, clears all stage valid bits; payload is not reset.
module dcf77_minute_frame_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  dcfd_in_if.sink          in_i,
  dcfd_out_if.source       out_o
);
  import dcfd_pkg::*;

  // Decoded values of one attempt (regular or leap-shifted)
  typedef struct packed {
    logic [2:0] st;
    logic [5:0] mi;
    logic [4:0] hr;
    logic [4:0] dom;
    logic [2:0] dow;
    logic [3:0] mo;
    logic [6:0] yr;
    logic       ann;
    logic       cest;
    logic       zone;
    logic       call;
  } rec_t;

  // Stage 2 work: BCD digit check, binary values, static range checks.
  function automatic rec_t bcd_range(dgt_t d);
    rec_t       r;
    logic [6:0] mi;
    logic [5:0] hr;
    logic [5:0] dom;
    logic [4:0] mo;
    logic [7:0] yr;
    logic       bcd_bad;
    logic       rng_bad;
    mi  = 7'(d.mu) + 7'({d.mt, 3'b000}) + 7'({d.mt, 1'b0});
    hr  = 6'(d.hu) + 6'({d.ht, 3'b000}) + 6'({d.ht, 1'b0});
    dom = 6'(d.du) + 6'({d.dt, 3'b000}) + 6'({d.dt, 1'b0});
    mo  = 5'(d.mou) + (d.mot ? 5'd10 : 5'd0);
    yr  = 8'(d.yu) + 8'({d.yt, 3'b000}) + 8'({d.yt, 1'b0});
    bcd_bad = (d.mu > 4'd9) || (d.hu > 4'd9) || (d.du > 4'd9) ||
              (d.mou > 4'd9) || (d.yu > 4'd9) || (d.yt > 4'd9);
    // day upper bound per month is applied in stage 3; 31 caps it here
    rng_bad = (mi > 7'd59) || (hr > 6'd23) || (d.dow == 3'd0) ||
              (mo == 5'd0) || (mo > 5'd12) || (dom == 6'd0) || (dom > 6'd31);
    if (!d.frame_ok) begin
      r.st = ST_FRAME;
    end else if (bcd_bad) begin
      r.st = ST_BCD;
    end else if (rng_bad) begin
      r.st = ST_RANGE;
    end else begin
      r.st = ST_OK;
    end
    r.mi   = mi[5:0];
    r.hr   = hr[4:0];
    r.dom  = dom[4:0];
    r.dow  = d.dow;
    r.mo   = mo[3:0];
    r.yr   = yr[6:0];
    r.ann  = d.ann;
    r.cest = d.cest;
    r.zone = d.zone;
    r.call = d.call;
    return r;
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] mo, logic [6:0] yr);
    logic [4:0] n;
    case (mo) inside
      4'd2:                   n = (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

  // Stage 3 work: day vs. month length, then leap-second consistency.
  function automatic logic [2:0] final_st(rec_t r, logic leap);
    logic [2:0] st;
    logic       m59;
    m59 = (r.mi == 6'd59);
    if (r.st != ST_OK) begin
      st = r.st;
    end else if (r.dom > month_days(r.mo, r.yr)) begin
      st = ST_RANGE;
    end else if (leap ? (!r.ann || !m59) : (r.ann && m59)) begin
      // leap minute needs announcement and minute 59; a regular minute
      // with both set missed its due leap second
      st = ST_LEAP_BAD;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

  // ---------------------------------------------------------------
  // Handshake: per-stage advance enables
  // ---------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: length class, framing/parity, digit pickup for both the
  // regular frame and the leap frame (word shifted right by one)
  // ---------------------------------------------------------------
  dgt_t dgt_reg, dgt_leap;
  dgt_t s1_reg_q, s1_leap_q;
  logic s1_short_q, s1_c44_q, s1_b0_q;

  dcfd_field_dec u_dec_reg (
    .frame_i (in_i.minute_word[FrameW-1:0]),
    .dgt_o   (dgt_reg)
  );

  dcfd_field_dec u_dec_leap (
    .frame_i (in_i.minute_word[FrameW:1]),
    .dgt_o   (dgt_leap)
  );

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_reg_q   <= dgt_reg;
      s1_leap_q  <= dgt_leap;
      // sentinel below bit 44 means fewer than 44 bits received
      s1_short_q <= (in_i.minute_word[WordW-1:FrameW] == '0);
      // exactly 44 bits: no leap retry
      s1_c44_q   <= (in_i.minute_word[WordW-1:FrameW+1] == '0);
      s1_b0_q    <= in_i.minute_word[0];
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: BCD and static range checks
  // ---------------------------------------------------------------
  rec_t s2_reg_q, s2_leap_q;
  logic s2_short_q, s2_c44_q, s2_b0_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_reg_q   <= bcd_range(s1_reg_q);
      s2_leap_q  <= bcd_range(s1_leap_q);
      s2_short_q <= s1_short_q;
      s2_c44_q   <= s1_c44_q;
      s2_b0_q    <= s1_b0_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: month length, leap consistency, attempt select, zeroing
  // ---------------------------------------------------------------
  logic [2:0] st_reg, st_leap;
  rec_t       out_d, out_q;
  logic       lsp_d, lsp_q;

  assign st_reg  = final_st(s2_reg_q, 1'b0);
  assign st_leap = final_st(s2_leap_q, 1'b1);

  always_comb begin
    out_d = '0;
    lsp_d = 1'b0;
    if (s2_short_q) begin
      out_d.st = ST_SHORT;
    end else if (st_reg == ST_OK) begin
      out_d    = s2_reg_q;
      out_d.st = ST_OK;
    end else if (s2_c44_q) begin
      out_d.st = st_reg;
    end else if (s2_b0_q) begin
      // dropped bit of a leap minute must be zero
      out_d.st = ST_LEAP_END;
    end else if (st_leap == ST_OK) begin
      out_d    = s2_leap_q;
      out_d.st = ST_OK;
      lsp_d    = 1'b1;
    end else begin
      out_d.st = st_leap;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q <= out_d;
      lsp_q <= lsp_d;
    end
  end

  assign out_o.valid                 = v3_q;
  assign out_o.status                = out_q.st;
  assign out_o.minute                = out_q.mi;
  assign out_o.hour                  = out_q.hr;
  assign out_o.month_day             = out_q.dom;
  assign out_o.weekday               = out_q.dow;
  assign out_o.month_number          = out_q.mo;
  assign out_o.year_in_century       = out_q.yr;
  assign out_o.summer_time           = out_q.cest;
  assign out_o.zone_change_announced = out_q.zone;
  assign out_o.leap_announced        = out_q.ann;
  assign out_o.leap_second_present   = lsp_q;
  assign out_o.abnormal_transmitter  = out_q.call;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_ok_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_OK) |->
      (out_o.minute <= 6'd59 && out_o.hour <= 5'd23 &&
       out_o.month_number >= 4'd1 && out_o.month_number <= 4'd12 &&
       out_o.month_day >= 5'd1 && out_o.weekday != 3'd0))
    else $error("ok result with out-of-range field");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |->
      (out_o.minute == 6'd0 && out_o.hour == 5'd0 &&
       out_o.month_day == 5'd0 && out_o.month_number == 4'd0 &&
       out_o.leap_second_present == 1'b0 && out_o.leap_announced == 1'b0))
    else $error("failed result carries nonzero fields");

  a_leap_cons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.leap_second_present) |->
      (out_o.minute == 6'd59 && out_o.leap_announced &&
       out_o.status == ST_OK))
    else $error("leap second without announcement at minute 59");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.status <= ST_LEAP_BAD))
    else $error("undefined status code");

endmodule

/* dv/tb.sv */
// Testbench for dcf77_minute_frame_decoder: directed and random minute words, in-order
// checking of every decoded result against a behavioral decoder held in this file.
// Depends on dcfd_pkg, dcfd_if and the decoder RTL.
module tb;
  import dcfd_pkg::*;

  localparam int unsigned PipeLatency = 3;
  localparam int unsigned StallCycles = 200;
  localparam int unsigned RandomWords = 990;

  // Decoded time code, one per minute word
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] month_day;
    logic [2:0] weekday;
    logic [3:0] month_number;
    logic [6:0] year_in_century;
    logic       summer_time;
    logic       zone_change_announced;
    logic       leap_announced;
    logic       leap_second_present;
    logic       abnormal_transmitter;
  } time_code_t;

  // Raw BCD digits and flag bits used to build a 44-bit frame
  typedef struct packed {
    logic [3:0] mu;
    logic [2:0] mt;
    logic [3:0] hu;
    logic [1:0] ht;
    logic [3:0] du;
    logic [1:0] dt;
    logic [2:0] dow;
    logic [3:0] mou;
    logic       mot;
    logic [3:0] yu;
    logic [3:0] yt;
    logic       call;
    logic       zone;
    logic       cest;
    logic       cet;
    logic       ann;
    logic       start;
  } frame_fields_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dcfd_in_if  in_if ();
  dcfd_out_if out_if ();

  dcf77_minute_frame_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  time_code_t pending_codes[$];
  time_code_t want_code;
  int         err_count = 0;
  bit         idle_en = 1'b1;
  int         stall_requests = 0;
  int         stall_served = 0;

  // ---------------------------------------------------------------------------
  // Behavioral decoder
  // ---------------------------------------------------------------------------
  function automatic int unsigned days_in_month(input int unsigned mo, input int unsigned yr);
    if (mo == 2) return (yr % 4 == 0) ? 29 : 28;
    if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
    return 31;
  endfunction

  // Decode the frame held in w[43:0]; fills tc on success
  function automatic logic [2:0] decode_frame(input logic [59:0] w, input bit leap,
                                              output time_code_t tc);
    logic [3:0]  mu, hu, du, mou, yu, yt;
    int unsigned mi, hr, dom, dow, mo, yr;
    tc = '0;
    if (w[41] == w[40] || !w[38]) return ST_FRAME;
    if ((^w[37:30]) || (^w[29:23]) || (^w[22:0])) return ST_FRAME;
    // higher index carries the lower weight
    mu  = {w[34], w[35], w[36], w[37]};
    hu  = {w[26], w[27], w[28], w[29]};
    du  = {w[19], w[20], w[21], w[22]};
    mou = {w[10], w[11], w[12], w[13]};
    yu  = {w[5], w[6], w[7], w[8]};
    yt  = {w[1], w[2], w[3], w[4]};
    if (mu >= 10 || hu >= 10 || du >= 10 || mou >= 10 || yu >= 10 || yt >= 10)
      return ST_BCD;
    mi  = mu + 10 * {w[31], w[32], w[33]};
    hr  = hu + 10 * {w[24], w[25]};
    dom = du + 10 * {w[17], w[18]};
    dow = {w[14], w[15], w[16]};
    mo  = mou + 10 * w[9];
    yr  = yu + 10 * yt;
    if (mi > 59 || hr > 23) return ST_RANGE;
    if (dow < 1 || mo < 1 || mo > 12 || dom < 1 || dom > days_in_month(mo, yr))
      return ST_RANGE;
    if (leap) begin
      if (!w[39] || mi != 59) return ST_LEAP_BAD;
    end else if (w[39] && mi == 59) begin
      return ST_LEAP_BAD;  // leap second was due but not received
    end
    tc.minute                = 6'(mi);
    tc.hour                  = 5'(hr);
    tc.month_day             = 5'(dom);
    tc.weekday               = 3'(dow);
    tc.month_number          = 4'(mo);
    tc.year_in_century       = 7'(yr);
    tc.summer_time           = w[41];
    tc.zone_change_announced = w[42];
    tc.leap_announced        = w[39];
    tc.leap_second_present   = leap;
    tc.abnormal_transmitter  = w[43];
    return ST_OK;
  endfunction

  function automatic time_code_t decode_minute_word(input logic [59:0] w);
    time_code_t  tc;
    logic [2:0]  st;
    int unsigned nbits;
    nbits = 0;
    for (int i = 0; i < 60; i++) if (w[i]) nbits = i;
    tc = '0;
    if (nbits < FrameW) begin
      st = ST_SHORT;
    end else begin
      st = decode_frame(w, 1'b0, tc);
      // retry as leap minute only when there is a bit to drop
      if (st != ST_OK && nbits >= FrameW + 1) begin
        if (w[0]) st = ST_LEAP_END;
        else      st = decode_frame(w >> 1, 1'b1, tc);
      end
    end
    if (st != ST_OK) tc = '0;
    tc.status = st;
    return tc;
  endfunction

  // ---------------------------------------------------------------------------
  // Word construction
  // ---------------------------------------------------------------------------
  function automatic frame_fields_t fields_from(input int unsigned mi, hr, dom, dow, mo, yr);
    frame_fields_t f;
    f = '0;
    f.mu = 4'(mi % 10);  f.mt = 3'(mi / 10);
    f.hu = 4'(hr % 10);  f.ht = 2'(hr / 10);
    f.du = 4'(dom % 10); f.dt = 2'(dom / 10);
    f.dow = 3'(dow);
    f.mou = 4'(mo % 10); f.mot = 1'(mo / 10);
    f.yu = 4'(yr % 10);  f.yt = 4'(yr / 10);
    f.call  = 1'($urandom_range(0, 1));
    f.zone  = 1'($urandom_range(0, 1));
    f.cest  = 1'($urandom_range(0, 1));
    f.cet   = ~f.cest;
    f.start = 1'b1;
    return f;
  endfunction

  function automatic frame_fields_t random_date_fields();
    frame_fields_t f;
    int unsigned   mo, yr;
    mo = $urandom_range(1, 12);
    yr = $urandom_range(0, 99);
    f = fields_from($urandom_range(0, 59), $urandom_range(0, 23),
                    $urandom_range(1, days_in_month(mo, yr)), $urandom_range(1, 7), mo, yr);
    f.ann = 1'($urandom_range(0, 1));
    return f;
  endfunction

  // Arbitrary digits: mostly BCD and range failures
  function automatic frame_fields_t random_raw_fields();
    frame_fields_t f;
    logic [63:0]   raw;
    raw = {$urandom, $urandom};
    f = raw[$bits(frame_fields_t)-1:0];
    f.start = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 9) != 0) f.cet = ~f.cest;
    return f;
  endfunction

  function automatic logic [43:0] make_frame(input frame_fields_t f);
    logic [43:0] fr;
    fr = '0;
    fr[43] = f.call;
    fr[42] = f.zone;
    fr[41] = f.cest;
    fr[40] = f.cet;
    fr[39] = f.ann;
    fr[38] = f.start;
    fr[37:34] = {f.mu[0], f.mu[1], f.mu[2], f.mu[3]};
    fr[33:31] = {f.mt[0], f.mt[1], f.mt[2]};
    fr[29:26] = {f.hu[0], f.hu[1], f.hu[2], f.hu[3]};
    fr[25:24] = {f.ht[0], f.ht[1]};
    fr[22:19] = {f.du[0], f.du[1], f.du[2], f.du[3]};
    fr[18:17] = {f.dt[0], f.dt[1]};
    fr[16:14] = {f.dow[0], f.dow[1], f.dow[2]};
    fr[13:10] = {f.mou[0], f.mou[1], f.mou[2], f.mou[3]};
    fr[9]     = f.mot;
    fr[8:5]   = {f.yu[0], f.yu[1], f.yu[2], f.yu[3]};
    fr[4:1]   = {f.yt[0], f.yt[1], f.yt[2], f.yt[3]};
    // even parity per group
    fr[30] = ^fr[37:31];
    fr[23] = ^fr[29:24];
    fr[0]  = ^fr[22:1];
    return fr;
  endfunction

  // Frame under a sentinel at bit nbits, random filler in between;
  // a leap word carries a trailing zero below the frame.
  function automatic logic [59:0] frame_word(input frame_fields_t f, input bit leap,
                                             input int unsigned nbits);
    logic [59:0]  body, pad;
    logic [63:0]  raw;
    int unsigned  body_w;
    body_w = leap ? FrameW + 1 : FrameW;
    body = leap ? {15'b0, make_frame(f), 1'b0} : {16'b0, make_frame(f)};
    raw = {$urandom, $urandom};
    pad = raw[59:0] & ((60'd1 << nbits) - 60'd1) & ~((60'd1 << body_w) - 60'd1);
    return pad | body | (60'd1 << nbits);
  endfunction

  function automatic int unsigned random_length(input bit leap);
    int unsigned base;
    base = leap ? FrameW + 1 : FrameW;
    return ($urandom_range(0, 9) < 7) ? base : $urandom_range(base, 59);
  endfunction

  function automatic logic [59:0] random_minute_word();
    frame_fields_t f;
    logic [63:0]   raw;
    logic [59:0]   w;
    int unsigned   pick, len;
    bit            as_leap;
    pick = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    if (pick >= 90) begin
      // noise: arbitrary word, half of them with a random length
      w = raw[59:0];
      if (raw[63]) begin
        len = $urandom_range(0, 59);
        w = (w & ((60'd1 << len) - 60'd1)) | (60'd1 << len);
      end
      return w;
    end
    if (pick >= 60 && pick < 75) f = random_raw_fields();
    else                         f = random_date_fields();
    as_leap = (pick >= 40 && pick < 60) || (pick >= 60 && $urandom_range(0, 2) == 0);
    if (as_leap) begin
      if ($urandom_range(0, 4) != 0) begin
        f.mu = 4'd9;
        f.mt = 3'd5;
      end
      f.ann = ($urandom_range(0, 4) != 0);
    end else if (pick < 40 && $urandom_range(0, 3) == 0) begin
      f.mu = 4'd9;
      f.mt = 3'd5;
    end
    w = frame_word(f, as_leap, random_length(as_leap));
    if (as_leap && $urandom_range(0, 9) == 0) w[0] = 1'b1;
    // corrupted frames: one or two flipped bits
    if (pick >= 75) begin
      w ^= 60'd1 << $urandom_range(0, 44);
      if (raw[0]) w ^= 60'd1 << $urandom_range(0, 44);
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers and checking
  // ---------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge where the item is taken.
  // valid stays high afterwards so back-to-back items need no re-raise.
  task automatic send_word(input logic [59:0] w);
    // idle decision per cycle, with a 37 percent chance of idling
    while (idle_en && $urandom_range(0, 99) < 37) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.minute_word <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_codes.push_back(decode_minute_word(w));
  endtask

  task automatic send_frame(input frame_fields_t f, input bit leap, input int unsigned nbits);
    send_word(frame_word(f, leap, nbits));
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 5) @(posedge clk_i);
  endtask

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_requests != stall_served) begin
        stall_served++;
        out_if.ready <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
      end else begin
        out_if.ready <= !(idle_en && $urandom_range(0, 99) < 37);
      end
    end
  end

  task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_codes.size() == 0) begin
        $error("status: expected none, actual %0d (no word pending)", out_if.status);
        err_count++;
      end else begin
        want_code = pending_codes.pop_front();
        check_field("status", 7'(want_code.status), 7'(out_if.status));
        check_field("minute", 7'(want_code.minute), 7'(out_if.minute));
        check_field("hour", 7'(want_code.hour), 7'(out_if.hour));
        check_field("month_day", 7'(want_code.month_day), 7'(out_if.month_day));
        check_field("weekday", 7'(want_code.weekday), 7'(out_if.weekday));
        check_field("month_number", 7'(want_code.month_number), 7'(out_if.month_number));
        check_field("year_in_century", want_code.year_in_century, out_if.year_in_century);
        check_field("summer_time", 7'(want_code.summer_time), 7'(out_if.summer_time));
        check_field("zone_change_announced", 7'(want_code.zone_change_announced),
                    7'(out_if.zone_change_announced));
        check_field("leap_announced", 7'(want_code.leap_announced),
                    7'(out_if.leap_announced));
        check_field("leap_second_present", 7'(want_code.leap_second_present),
                    7'(out_if.leap_second_present));
        check_field("abnormal_transmitter", 7'(want_code.abnormal_transmitter),
                    7'(out_if.abnormal_transmitter));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty and short words, the all-ones word, trailing one on a leap word
  task automatic test_length_and_end_bit();
    frame_fields_t f;
    logic [59:0]   w;
    send_word('0);
    send_word((60'd1 << FrameW) - 60'd1);
    send_word({60{1'b1}});
    f = fields_from(59, 23, 31, 7, 12, 99);
    f.ann = 1'b1;
    w = frame_word(f, 1'b1, FrameW + 1);
    w[0] = 1'b1;
    send_word(w);
    wait_idle();
  endtask

  // Field extremes, calendar limits, BCD digits out of range
  task automatic test_calendar_frames();
    frame_fields_t f;
    f = fields_from(59, 23, 31, 7, 12, 99);
    f.call = 1'b1; f.zone = 1'b1; f.cest = 1'b1; f.cet = 1'b0;
    send_frame(f, 1'b0, FrameW);
    f = fields_from(0, 0, 1, 1, 1, 0);
    f.call = 1'b0; f.zone = 1'b0; f.cest = 1'b0; f.cet = 1'b1;
    send_frame(f, 1'b0, 59);
    send_frame(fields_from(30, 12, 29, 4, 2, 24), 1'b0, FrameW);  // leap year Feb 29
    send_frame(fields_from(30, 12, 29, 4, 2, 23), 1'b0, FrameW);  // common year Feb 29
    send_frame(fields_from(15, 8, 31, 3, 4, 50), 1'b0, FrameW);   // 31 April
    send_frame(fields_from(15, 8, 0, 3, 5, 50), 1'b0, FrameW);    // day zero
    send_frame(fields_from(15, 8, 10, 3, 0, 50), 1'b0, FrameW);   // month zero
    send_frame(fields_from(15, 8, 10, 3, 13, 50), 1'b0, FrameW);  // month 13
    send_frame(fields_from(15, 8, 10, 0, 6, 50), 1'b0, FrameW);   // weekday zero
    send_frame(fields_from(60, 8, 10, 3, 6, 50), 1'b0, FrameW);   // minute 60
    send_frame(fields_from(15, 24, 10, 3, 6, 50), 1'b0, FrameW);  // hour 24
    f = fields_from(10, 10, 10, 3, 10, 10);
    f.mu = 4'd10;
    send_frame(f, 1'b0, FrameW);
    f = fields_from(10, 10, 10, 3, 10, 10);
    f.yt = 4'd15;
    send_frame(f, 1'b0, FrameW);
    wait_idle();
  endtask

  // Parity, CET/CEST pair and start bit
  task automatic test_frame_checks();
    frame_fields_t f;
    f = fields_from(42, 17, 15, 5, 8, 33);
    send_word(frame_word(f, 1'b0, FrameW) ^ (60'd1 << 30));
    f.cest = 1'b1; f.cet = 1'b1;
    send_frame(f, 1'b0, FrameW);
    f = fields_from(42, 17, 15, 5, 8, 33);
    f.start = 1'b0;
    send_frame(f, 1'b0, FrameW);
    wait_idle();
  endtask

  // Leap minute accepted, leap without announcement, announced but not inserted
  task automatic test_leap_second();
    frame_fields_t f;
    f = fields_from(59, 23, 30, 2, 6, 15);
    f.ann = 1'b1;
    send_frame(f, 1'b1, FrameW + 1);
    f.ann = 1'b0;
    send_frame(f, 1'b1, FrameW + 1);
    f.ann = 1'b1;
    send_frame(f, 1'b0, FrameW);
    wait_idle();
  endtask

  // Result side held off while words keep coming; pipeline fills and stalls input
  task automatic test_backpressure();
    idle_en = 1'b0;
    stall_requests++;
    repeat (40) send_word(frame_word(random_date_fields(), 1'b0, FrameW));
    idle_en = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_words();
    for (int i = 0; i < RandomWords; i++) begin
      idle_en = !(i >= 300 && i < 500);  // one long stretch at full rate
      send_word(random_minute_word());
    end
    idle_en = 1'b1;
    wait_idle();
  endtask

  initial begin
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.minute_word <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_length_and_end_bit();
    test_calendar_frames();
    test_frame_checks();
    test_leap_second();
    test_backpressure();
    test_random_words();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
